### sv/semt_pkg.sv
// ----------------------------------------------------------------------------
// semt_pkg - shared types and constants for the sorted event merge table
// Beat payload structs, status codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package semt_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TIME_W  = 32;
    localparam int DIN_W   = 32;
    localparam int DACC_W  = 40;
    localparam int ENTRY_W = TIME_W + DACC_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_MERGED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic                     func;
        logic [TIME_W-1:0]        event_time;
        logic signed [DIN_W-1:0]  bandwidth_delta;
    } in_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic [TIME_W-1:0]        out_time;
        logic signed [DACC_W-1:0] out_delta;
        logic signed [DACC_W-1:0] net_total;
        logic                     last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RD_RD,
        S_RD_EMIT
    } state_t;

    typedef enum logic [1:0] {
        WR_MERGE,
        WR_SHIFT,
        WR_NEW
    } wr_sel_t;

    typedef enum logic [2:0] {
        OUT_EMPTY,
        OUT_MERGED,
        OUT_DROPPED,
        OUT_NEW,
        OUT_READ
    } out_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     idx_load_top;
        logic     pos_set_idx;
        logic     pos_set_count;
        logic     ram_we;
        wr_sel_t  wr_sel;
        logic     out_load;
        out_sel_t out_sel;
        logic     cnt_inc;
        logic     net_clr;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic cnt_zero;
        logic full;
        logic rd_eq;
        logic rd_gt;
        logic idx_last;
        logic idx_eq_pos;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### sv/semt_ram.sv
// ----------------------------------------------------------------------------
// semt_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/semt_ctrl.sv
// ----------------------------------------------------------------------------
// semt_ctrl - sequencing controller
// Walks search, shift, write and readout steps; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire semt_pkg::stat_t stat,
    output semt_pkg::cmd_t      cmd
);

    import semt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START: begin
                if (stat.func == FUNC_READ) begin
                    if (stat.cnt_zero) begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_EMPTY;
                            state_next   = S_IDLE;
                        end
                    end else begin
                        cmd.idx_clr = 1'b1;
                        cmd.net_clr = 1'b1;
                        state_next  = S_RD_RD;
                    end
                end else if (stat.cnt_zero) begin
                    cmd.pos_set_count = 1'b1;
                    state_next        = S_PUT;
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                priority if (stat.rd_eq) begin
                    if (stat.out_free) begin
                        cmd.ram_we   = 1'b1;
                        cmd.wr_sel   = WR_MERGE;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_MERGED;
                        state_next   = S_IDLE;
                    end
                end else if ((stat.rd_gt || stat.idx_last) && stat.full) begin
                    if (stat.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_DROPPED;
                        state_next   = S_IDLE;
                    end
                end else if (stat.rd_gt) begin
                    cmd.pos_set_idx  = 1'b1;
                    cmd.idx_load_top = 1'b1;
                    state_next       = S_SHIFT_RD;
                end else if (stat.idx_last) begin
                    cmd.pos_set_count = 1'b1;
                    state_next        = S_PUT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.ram_we = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                if (stat.idx_eq_pos) begin
                    state_next = S_PUT;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SHIFT_RD;
                end
            end
            S_PUT: begin
                if (stat.out_free) begin
                    cmd.ram_we   = 1'b1;
                    cmd.wr_sel   = WR_NEW;
                    cmd.cnt_inc  = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_NEW;
                    state_next   = S_IDLE;
                end
            end
            S_RD_RD: begin
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_READ;
                    if (stat.idx_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/semt_dp.sv
// ----------------------------------------------------------------------------
// semt_dp - table datapath
// Entry RAM, item register, index/position/count, saturating adders and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire semt_pkg::in_item_t s_data,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output semt_pkg::out_item_t    m_data,
    input  wire semt_pkg::cmd_t    cmd,
    output semt_pkg::stat_t        stat
);

    import semt_pkg::*;

    // clamp a 41-bit sum to the signed 40-bit range
    function automatic logic signed [DACC_W-1:0] sat40(input logic signed [DACC_W:0] v);
        logic signed [DACC_W-1:0] r;
        if (v[DACC_W] != v[DACC_W-1]) begin
            r = v[DACC_W] ? {1'b1, {(DACC_W-1){1'b0}}} : {1'b0, {(DACC_W-1){1'b1}}};
        end else begin
            r = v[DACC_W-1:0];
        end
        return r;
    endfunction

    in_item_t                 item_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;
    logic [IDX_W-1:0]         pos_reg;
    logic [IDX_W-1:0]         pos_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic signed [DACC_W-1:0] net_reg;
    logic signed [DACC_W-1:0] net_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    out_item_t                m_data_reg;
    out_item_t                m_data_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [TIME_W-1:0]        rd_time;
    logic signed [DACC_W-1:0] rd_delta;
    logic signed [DACC_W-1:0] d_ext;
    logic signed [DACC_W-1:0] merged;
    logic signed [DACC_W-1:0] net_sum;

    semt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_time  = ram_rdata[ENTRY_W-1:DACC_W];
    assign rd_delta = ram_rdata[DACC_W-1:0];
    assign d_ext    = {{(DACC_W-DIN_W){item_reg.bandwidth_delta[DIN_W-1]}},
                       item_reg.bandwidth_delta};
    assign merged   = sat40({rd_delta[DACC_W-1], rd_delta} + {d_ext[DACC_W-1], d_ext});
    assign net_sum  = sat40({net_reg[DACC_W-1], net_reg} + {rd_delta[DACC_W-1], rd_delta});

    // status back to the controller
    always_comb begin
        stat.func       = item_reg.func;
        stat.cnt_zero   = (cnt_reg == '0);
        stat.full       = (cnt_reg == CNT_W'(DEPTH));
        stat.rd_eq      = (rd_time == item_reg.event_time);
        stat.rd_gt      = (rd_time > item_reg.event_time);
        stat.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
        stat.idx_eq_pos = (idx_reg == pos_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // table write port
    always_comb begin
        ram_we = cmd.ram_we;
        unique case (cmd.wr_sel)
            WR_MERGE: begin
                ram_waddr = idx_reg;
                ram_wdata = {item_reg.event_time, merged};
            end
            WR_SHIFT: begin
                ram_waddr = idx_reg + IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            WR_NEW: begin
                ram_waddr = pos_reg;
                ram_wdata = {item_reg.event_time, d_ext};
            end
            default: begin
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
            end
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        priority if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_load_top) begin
            idx_next = IDX_W'(cnt_reg - CNT_W'(1));
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - IDX_W'(1);
        end

        pos_next = pos_reg;
        priority if (cmd.pos_set_idx) begin
            pos_next = idx_reg;
        end else if (cmd.pos_set_count) begin
            pos_next = IDX_W'(cnt_reg);
        end

        cnt_next = cmd.cnt_inc ? cnt_reg + CNT_W'(1) : cnt_reg;

        net_next = net_reg;
        if (cmd.net_clr) begin
            net_next = '0;
        end else if (cmd.out_load && cmd.out_sel == OUT_READ) begin
            net_next = net_sum;
        end
    end

    // result register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.out_load) begin
            m_valid_next          = 1'b1;
            m_data_next.out_time  = item_reg.event_time;
            m_data_next.out_delta = '0;
            m_data_next.net_total = '0;
            m_data_next.last      = 1'b1;
            unique case (cmd.out_sel)
                OUT_EMPTY: begin
                    m_data_next.status   = ST_EMPTY;
                    m_data_next.out_time = '0;
                end
                OUT_MERGED: begin
                    m_data_next.status    = ST_MERGED;
                    m_data_next.out_delta = merged;
                end
                OUT_DROPPED: begin
                    m_data_next.status = ST_DROPPED;
                end
                OUT_NEW: begin
                    m_data_next.status    = ST_NEW;
                    m_data_next.out_delta = d_ext;
                end
                OUT_READ: begin
                    m_data_next.status    = ST_READ;
                    m_data_next.out_time  = rd_time;
                    m_data_next.out_delta = rd_delta;
                    m_data_next.net_total = net_sum;
                    m_data_next.last      = stat.idx_last;
                end
                default: begin
                    m_data_next.status = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        net_reg    <= net_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### sv/sorted_event_merge_table_core.sv
// ----------------------------------------------------------------------------
// sorted_event_merge_table_core - time-sorted event table with key merge
// Insert beats add a signed change at a time (merging equal times); readout
// beats stream every entry in time order with a saturating running total.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat is an item (func, event_time, bandwidth_delta).
//   m_ channel: result beats; one per insert, one per entry per readout
//   (a single "table empty" beat when nothing is stored); last marks the
//   final beat of an item.
//   One item is worked at a time; s_ready is high only between items.
//   Insert: the table RAM is scanned from the lowest time, one entry at a
//   time, then entries above the slot move up one at a time, from the top
//   down; a merge or a drop ends the scan early. Readout reads and emits
//   the entries one at a time, each read waiting on the entry RAM's
//   registered read. A stalled m_ready holds the result register; the
//   sequence goes on to its next result step and waits there until the
//   beat is taken; no beat is lost or repeated.
//   Reset (aresetn low, synchronous) empties the table at once; stored
//   entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_merge_table_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire semt_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output semt_pkg::out_item_t     m_data
);

    import semt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing: search, shift, write, readout
    semt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, arithmetic and the result register
    semt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

`ifndef SYNTHESIS
    // a new result never overwrites one still waiting
    a_out_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten");

    // a full table never grows
    a_no_grow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !stat.full)
        else $error("entry added to full table");

    // shifting entries up only happens with room at the top
    a_shift_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ram_we && cmd.wr_sel == WR_SHIFT) |-> !stat.full)
        else $error("shift on full table");

    // one item in flight: no beat taken in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");
`endif

endmodule

`default_nettype wire
